/* design/cdc_pkg.sv */
// Shared types and constants for the cluster dispatch control registers.
package cdc_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } state_t;

    localparam logic [3:0]  LEGAL_SIZE        = 4'd4;
    localparam logic [7:0]  VECTOR_LAST_OFS   = 8'h18;
    localparam logic [2:0]  CLUSTER_BASE_HI   = 3'b010;
    localparam logic [31:0] ENTRY_RESET       = 32'hCC00_0080;
    localparam int          CORE_COUNT_W      = 7;
    localparam logic [CORE_COUNT_W-1:0] CORE_COUNT_RESET = 7'd8;
    localparam int          PADDR_W           = 3;
    localparam logic [PADDR_W-1:0] ADDR_CORE_COUNT = 3'd0;

    localparam logic [2:0] V_CLK_EN  = 3'd0;
    localparam logic [2:0] V_START   = 3'd2;
    localparam logic [2:0] V_DONE    = 3'd6;
    localparam logic [2:0] C_CLK_EN  = 3'd0;
    localparam logic [2:0] C_BINARY  = 3'd1;
    localparam logic [2:0] C_DONE    = 3'd2;
    localparam logic [2:0] C_START   = 3'd5;
    localparam logic [2:0] C_READY   = 3'd6;

endpackage

/* design/cluster_dispatch_control_regs.sv */
// Top level of the cluster dispatch control registers.
// One item (bus read, bus write, clock tick or no-op) is accepted while the block is idle;
// its result then passes from the lookup state into the output register. The register bank
// lives in a synchronous memory with a registered read, and no new item is taken while a
// lookup is under way. A finished result waits in the output register while the next item
// is taken; the lookup of that next item stalls, and with it the input, for as long as the
// waiting result is not taken.
// Done and doorbell pulses stay high until the next tick item. The core count register at
// byte address 0 of the configuration port sets how many boot reports make READY true.
module cluster_dispatch_control_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       command,
    input  logic [7:0]                       byte_offset,
    input  logic [3:0]                       access_size,
    input  logic [31:0]                      write_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [31:0]                      read_data,
    output logic                             error,
    output logic                             vector_clock_enable,
    output logic                             vector_start_irq,
    output logic                             vector_done_irq,
    output logic                             cluster_clock_enable,
    output logic                             cluster_doorbell,
    output logic                             cluster_done_irq,
    output logic [31:0]                      cluster_entry_point,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cdc_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import cdc_pkg::*;

    state_t state_reg, state_next;

    logic [31:0] mem [16];
    logic [15:0] mem_valid_reg;
    logic [31:0] mem_q_reg;

    logic [CORE_COUNT_W-1:0] core_count_reg;
    logic [CORE_COUNT_W-1:0] ready_cnt_reg, ready_cnt_next;
    logic ready_reg, ready_next;
    logic start_reg, start_next;
    logic vclk_reg, vclk_next;
    logic vstart_reg, vstart_next;
    logic vdone_reg, vdone_next;
    logic cclk_reg, cclk_next;
    logic bell_reg, bell_next;
    logic cdone_reg, cdone_next;
    logic [31:0] entry_reg, entry_next;

    logic        lk_sel_mem_reg, lk_valid_reg, lk_err_reg;
    logic [31:0] lk_value_reg;

    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic        out_err_reg;
    logic [5:0]  out_wires_reg;
    logic [31:0] out_entry_reg;

    logic        accept;
    logic        is_rd, is_wr, size_ok, hit_vec, hit_cl;
    logic [2:0]  idx;
    logic [3:0]  mem_addr;
    logic        acc_err;
    logic        mem_we, mem_re;
    logic        rd_sel_mem;
    logic [31:0] rd_value;
    logic        lookup_done;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign is_rd    = (command == CMD_READ);
    assign is_wr    = (command == CMD_WRITE);
    assign size_ok  = (access_size == LEGAL_SIZE);
    assign idx      = byte_offset[4:2];
    assign hit_vec  = size_ok && (byte_offset[1:0] == 2'b00) && (byte_offset <= VECTOR_LAST_OFS);
    assign hit_cl   = size_ok && (byte_offset[1:0] == 2'b00) && (byte_offset[7:5] == CLUSTER_BASE_HI);
    assign mem_addr = {hit_cl, idx};

    always_comb
    begin
        acc_err = 1'b0;
        if (is_rd || is_wr)
        begin
            if (!size_ok)
            begin
                acc_err = 1'b1;
            end
            else if (hit_vec)
            begin
                if (is_rd)
                begin
                    acc_err = (idx == V_DONE);
                end
                else
                begin
                    acc_err = ((idx == V_CLK_EN) || (idx == V_START)) && (write_data > 32'd1);
                end
            end
        end
    end

    assign mem_we = accept && is_wr && (hit_vec || hit_cl) && !acc_err;

    always_comb
    begin
        rd_sel_mem = 1'b0;
        rd_value   = 32'd0;
        if (is_rd && !acc_err)
        begin
            if (hit_vec)
            begin
                case (idx)
                    V_CLK_EN: rd_value = {31'd0, vclk_reg};
                    V_START:  rd_value = {31'd0, vstart_reg};
                    default:  rd_sel_mem = 1'b1;
                endcase
            end
            else if (hit_cl)
            begin
                case (idx)
                    C_DONE:   rd_value = {31'd0, cdone_reg};
                    C_START:  rd_value = {31'd0, start_reg};
                    C_READY:  rd_value = {31'd0, ready_reg};
                    C_BINARY:
                    begin
                        rd_sel_mem = 1'b1;
                        rd_value   = ENTRY_RESET;
                    end
                    default:  rd_sel_mem = 1'b1;
                endcase
            end
        end
    end

    assign mem_re = accept && rd_sel_mem;

    always_comb
    begin
        ready_cnt_next = ready_cnt_reg;
        ready_next     = ready_reg;
        start_next     = start_reg;
        vclk_next      = vclk_reg;
        vstart_next    = vstart_reg;
        vdone_next     = vdone_reg;
        cclk_next      = cclk_reg;
        bell_next      = bell_reg;
        cdone_next     = cdone_reg;
        entry_next     = entry_reg;
        if (accept)
        begin
            if (command == CMD_TICK)
            begin
                vdone_next = 1'b0;
                cdone_next = 1'b0;
                bell_next  = 1'b0;
            end
            else if (mem_we && hit_vec)
            begin
                case (idx)
                    V_CLK_EN: vclk_next   = write_data[0];
                    V_START:  vstart_next = write_data[0];
                    V_DONE:   vdone_next  = 1'b1;
                    default:  vdone_next  = vdone_reg;
                endcase
            end
            else if (mem_we && hit_cl)
            begin
                case (idx)
                    C_CLK_EN:
                    begin
                        cclk_next      = (write_data != 32'd0);
                        ready_cnt_next = '0;
                        ready_next     = 1'b0;
                    end
                    C_BINARY: entry_next = write_data;
                    C_DONE:   cdone_next = 1'b1;
                    C_START:
                    begin
                        start_next = (write_data != 32'd0);
                        if (write_data != 32'd0)
                        begin
                            bell_next = 1'b1;
                        end
                    end
                    C_READY:
                    begin
                        if (ready_cnt_reg < core_count_reg)
                        begin
                            ready_cnt_next = ready_cnt_reg + CORE_COUNT_W'(1);
                        end
                        if (ready_cnt_next == core_count_reg)
                        begin
                            ready_next = 1'b1;
                        end
                    end
                    default:  entry_next = entry_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= write_data;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lk_sel_mem_reg <= rd_sel_mem;
            lk_valid_reg   <= mem_valid_reg[mem_addr];
            lk_err_reg     <= acc_err;
            lk_value_reg   <= rd_value;
        end
    end

    assign lookup_done = (state_reg == S_LOOKUP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_LOOKUP;
            S_LOOKUP: if (lookup_done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mem_valid_reg  <= '0;
            core_count_reg <= CORE_COUNT_RESET;
            ready_cnt_reg  <= '0;
            ready_reg      <= 1'b0;
            start_reg      <= 1'b0;
            vclk_reg       <= 1'b0;
            vstart_reg     <= 1'b0;
            vdone_reg      <= 1'b0;
            cclk_reg       <= 1'b0;
            bell_reg       <= 1'b0;
            cdone_reg      <= 1'b0;
            entry_reg      <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_cnt_reg <= ready_cnt_next;
            ready_reg     <= ready_next;
            start_reg     <= start_next;
            vclk_reg      <= vclk_next;
            vstart_reg    <= vstart_next;
            vdone_reg     <= vdone_next;
            cclk_reg      <= cclk_next;
            bell_reg      <= bell_next;
            cdone_reg     <= cdone_next;
            entry_reg     <= entry_next;
            if (mem_we)
            begin
                mem_valid_reg[mem_addr] <= 1'b1;
            end
            if (psel && penable && pwrite && pready && (paddr == ADDR_CORE_COUNT))
            begin
                core_count_reg <= pwdata[CORE_COUNT_W-1:0];
            end
            if (lookup_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_done)
        begin
            out_rdata_reg <= (lk_sel_mem_reg && lk_valid_reg) ? mem_q_reg : lk_value_reg;
            out_err_reg   <= lk_err_reg;
            out_wires_reg <= {cdone_reg, bell_reg, cclk_reg, vdone_reg, vstart_reg, vclk_reg};
            out_entry_reg <= entry_reg;
        end
    end

    assign out_valid            = out_valid_reg;
    assign read_data            = out_rdata_reg;
    assign error                = out_err_reg;
    assign vector_clock_enable  = out_wires_reg[0];
    assign vector_start_irq     = out_wires_reg[1];
    assign vector_done_irq      = out_wires_reg[2];
    assign cluster_clock_enable = out_wires_reg[3];
    assign cluster_doorbell     = out_wires_reg[4];
    assign cluster_done_irq     = out_wires_reg[5];
    assign cluster_entry_point  = out_entry_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CORE_COUNT) ?
                    {{(32-CORE_COUNT_W){1'b0}}, core_count_reg} : 32'd0;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LOOKUP))
        else $error("Accepted item did not start a lookup.");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOOKUP))
        else $error("Result appeared without a lookup.");

    a_tick_clears_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_TICK)) |=> (!vdone_reg && !cdone_reg && !bell_reg))
        else $error("Tick item left a pulse high.");

    a_bad_enable_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_wr && size_ok && (byte_offset == 8'h00) && (write_data > 32'd1))
        |=> $stable(vclk_reg))
        else $error("Illegal vector clock enable value changed the wire.");

    a_ready_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> (ready_cnt_reg == core_count_reg))
        else $error("READY rose before the count was reached.");

endmodule
